### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of i_clk while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every rising edge of i_clk, reset included.
`define ASSERT_CLK_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// mbsp_pkg
// Status codes and the message type of the MIDI byte stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mbsp_pkg;

    // Upper nibbles of channel status bytes
    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_PRES = 4'hA;
    localparam logic [3:0] NIB_CTRL      = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRES = 4'hD;
    localparam logic [3:0] NIB_PITCH     = 4'hE;
    localparam logic [3:0] NIB_SYSTEM    = 4'hF;

    // System status bytes
    localparam logic [7:0] ST_NONE       = 8'h00;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_MTC_QF     = 8'hF1;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQ   = 8'hF6;
    localparam logic [7:0] ST_RT_FIRST   = 8'hF8;

    // Controllers from this number up are channel mode messages
    localparam logic [6:0] CTRL_MODE_FIRST = 7'd120;

    localparam int unsigned OUT_BITS  = 26;
    localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef struct packed {
        logic [6:0] second_value;
        logic [6:0] first_value;
        logic [3:0] channel;
        logic [7:0] message_kind;
    } t_midi_msg;

endpackage

`default_nettype wire

### rtl/midi_byte_stream_parser.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_parser
// Decodes a received MIDI byte stream into messages, with running status.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   8      rx_byte
//  m_axis    out  32     message_kind, channel, first_value, second_value
//
//  One byte per cycle while no stalled result holds it back; a byte passes
//  the input register and then the decode into the result register.
//  Running status is updated as the byte leaves the input register.
//  A stalled result blocks only bytes that would produce a result.
//  Synchronous active-low reset clears running status and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module midi_byte_stream_parser
    import mbsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] message_kind, [11:8] channel, [18:12] first_value,
    // [25:19] second_value, [31:26] zero
    output logic [OUT_BYTES*8-1:0] m_axis_tdata
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic [7:0] r_rs, n_rs;
    logic       r_held, n_held;
    logic [6:0] r_first, n_first;

    logic      r_out_valid;
    t_midi_msg r_out, n_out;
    logic      n_emit;

    logic       advance;
    logic [6:0] data;
    logic [3:0] ch;

    assign data = r_in_byte[6:0];
    assign ch   = r_rs[3:0];

    always_comb begin
        n_rs    = r_rs;
        n_held  = r_held;
        n_first = r_first;
        n_emit  = 1'b0;
        n_out   = '0;

        if (r_in_byte[7]) begin
            if (r_in_byte < ST_SYSEX) begin
                n_rs   = r_in_byte;
                n_held = 1'b0;
            end else if (r_in_byte >= ST_RT_FIRST) begin
                // real-time: pass through, state untouched
                n_emit             = 1'b1;
                n_out.message_kind = r_in_byte;
            end else begin
                case (r_in_byte)
                    ST_SYSEX: begin
                        n_rs = r_in_byte;
                    end
                    ST_MTC_QF, ST_SONG_POS, ST_SONG_SEL: begin
                        n_rs   = r_in_byte;
                        n_held = 1'b0;
                    end
                    ST_TUNE_REQ: begin
                        n_rs               = ST_NONE;
                        n_emit             = 1'b1;
                        n_out.message_kind = r_in_byte;
                    end
                    default: begin
                        n_rs = ST_NONE;
                    end
                endcase
            end
        end else begin
            case (r_rs[7:4])
                NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRES, NIB_CTRL, NIB_PITCH: begin
                    if (!r_held) begin
                        n_first = data;
                        n_held  = 1'b1;
                    end else begin
                        n_held        = 1'b0;
                        n_emit        = 1'b1;
                        n_out.channel = ch;
                        if (r_rs[7:4] == NIB_CTRL && r_first >= CTRL_MODE_FIRST) begin
                            n_out.message_kind = {1'b0, r_first};
                            n_out.first_value  = data;
                            n_out.second_value = data;
                        end else begin
                            n_out.message_kind = r_rs;
                            n_out.first_value  = r_first;
                            n_out.second_value = data;
                        end
                    end
                end
                NIB_PROGRAM, NIB_CHAN_PRES: begin
                    n_emit             = 1'b1;
                    n_out.message_kind = r_rs;
                    n_out.channel      = ch;
                    n_out.first_value  = data;
                end
                NIB_SYSTEM: begin
                    case (r_rs)
                        ST_MTC_QF: begin
                            n_rs               = ST_NONE;
                            n_held             = 1'b0;
                            n_emit             = 1'b1;
                            n_out.message_kind = r_rs;
                            n_out.first_value  = {4'd0, data[6:4]};
                            n_out.second_value = {3'd0, data[3:0]};
                        end
                        ST_SONG_SEL: begin
                            n_rs               = ST_NONE;
                            n_held             = 1'b0;
                            n_emit             = 1'b1;
                            n_out.message_kind = r_rs;
                            n_out.first_value  = data;
                        end
                        ST_SONG_POS: begin
                            if (!r_held) begin
                                n_first = data;
                                n_held  = 1'b1;
                            end else begin
                                n_rs               = ST_NONE;
                                n_held             = 1'b0;
                                n_emit             = 1'b1;
                                n_out.message_kind = r_rs;
                                n_out.first_value  = r_first;
                                n_out.second_value = data;
                            end
                        end
                        default: begin
                            // drop SysEx data
                        end
                    endcase
                end
                default: begin
                    // no running status: drop
                end
            endcase
        end
    end

    // A byte that yields no result may leave even while the result waits.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready || !n_emit);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rs        <= ST_NONE;
            r_held      <= 1'b0;
            r_first     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_rs    <= n_rs;
                r_held  <= n_held;
                r_first <= n_first;
            end
            if (advance && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, r_out};

    `ASSERT_CLK_ANY(a_reset_clears_out, !i_rst_n |=> !r_out_valid, "result valid after reset")
    `ASSERT_CLK(a_rs_is_status, r_rs[7] || r_rs == ST_NONE, "running status is a data byte")
    `ASSERT_CLK(a_held_kind, r_held |-> !(r_rs[7:4] == NIB_PROGRAM || r_rs[7:4] == NIB_CHAN_PRES || r_rs == ST_MTC_QF || r_rs == ST_SONG_SEL), "held byte under one-byte status")
    `ASSERT_CLK(a_realtime_keeps_state, advance && r_in_byte >= ST_RT_FIRST |=> r_rs == $past(r_rs) && r_held == $past(r_held), "real-time byte changed state")

endmodule

`default_nettype wire

### sim/midi_byte_stream_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_test
// Self-checking bench for the MIDI byte stream parser. Feeds directed byte
// sequences (voice, channel mode, system common, real-time, SysEx) and then
// random message streams with running status, noise and broken messages,
// with random gaps on the input and random stalls on the output. A local
// decoder tracks running status and predicts each message, which is then
// compared field by field with the transfers seen on the output.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_test
    import mbsp_pkg::*;
();

    // Status bytes the package does not name, and the largest data value
    localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
    localparam logic [7:0] ST_SYSEX_END = 8'hF7;
    localparam logic [7:0] ST_RT_LAST   = 8'hFF;
    localparam logic [6:0] DATA_MAX     = 7'h7F;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned RANDOM_BYTES = 800;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;  // [7:0] rx_byte

    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // [7:0] message_kind, [11:8] channel, [18:12] first_value,
    // [25:19] second_value, [31:26] zero
    logic [OUT_BYTES*8-1:0] m_axis_tdata;

    midi_byte_stream_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Decoder state mirrored from the stream
    logic [7:0] run_status = ST_NONE;
    logic       data_held = 1'b0;
    logic [6:0] held_data = 7'd0;
    t_midi_msg  pending_msgs[$];

    int unsigned n_errors = 0;
    int unsigned bytes_sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;
    logic [7:0] gen_status = ST_NONE;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic void push_msg(logic [7:0] kind, logic [3:0] ch,
                                     logic [6:0] v1, logic [6:0] v2);
        t_midi_msg m;
        m.message_kind = kind;
        m.channel      = ch;
        m.first_value  = v1;
        m.second_value = v2;
        pending_msgs.push_back(m);
    endfunction

    // Advance the decoder by one received byte, queue any message it completes
    function automatic void decode_byte(logic [7:0] b);
        logic [6:0] d;
        logic [3:0] ch;
        d  = b[6:0];
        ch = run_status[3:0];
        if (b[7]) begin
            if (b < ST_SYSEX) begin
                run_status = b;
                data_held = 1'b0;
            end else if (b >= ST_RT_FIRST) begin
                push_msg(b, 4'd0, 7'd0, 7'd0);
            end else begin
                case (b)
                    ST_SYSEX: run_status = b;
                    ST_MTC_QF, ST_SONG_POS, ST_SONG_SEL: begin
                        run_status = b;
                        data_held = 1'b0;
                    end
                    ST_TUNE_REQ: begin
                        push_msg(b, 4'd0, 7'd0, 7'd0);
                        run_status = ST_NONE;
                    end
                    default: run_status = ST_NONE;
                endcase
            end
        end else begin
            case (run_status[7:4])
                NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRES, NIB_CTRL, NIB_PITCH: begin
                    if (!data_held) begin
                        held_data = d;
                        data_held = 1'b1;
                    end else begin
                        data_held = 1'b0;
                        if (run_status[7:4] == NIB_CTRL && held_data >= CTRL_MODE_FIRST)
                            push_msg({1'b0, held_data}, ch, d, d);
                        else
                            push_msg(run_status, ch, held_data, d);
                    end
                end
                NIB_PROGRAM, NIB_CHAN_PRES: push_msg(run_status, ch, d, 7'd0);
                NIB_SYSTEM: begin
                    // system common messages end running status once complete
                    case (run_status)
                        ST_MTC_QF: begin
                            push_msg(run_status, 4'd0, {4'd0, d[6:4]}, {3'd0, d[3:0]});
                            run_status = ST_NONE;
                            data_held = 1'b0;
                        end
                        ST_SONG_SEL: begin
                            push_msg(run_status, 4'd0, d, 7'd0);
                            run_status = ST_NONE;
                            data_held = 1'b0;
                        end
                        ST_SONG_POS: begin
                            if (!data_held) begin
                                held_data = d;
                                data_held = 1'b1;
                            end else begin
                                push_msg(run_status, 4'd0, held_data, d);
                                run_status = ST_NONE;
                                data_held = 1'b0;
                            end
                        end
                        default: ;  // drop SysEx data
                    endcase
                end
                default: ;  // no running status
            endcase
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    // Check output transfers first, then track input transfers
    always @(posedge i_clk) begin
        t_midi_msg got;
        t_midi_msg want;
        if (!i_rst_n) begin
            run_status = ST_NONE;
            data_held = 1'b0;
            held_data = 7'd0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[OUT_BITS-1:0];
                if (pending_msgs.size() == 0) begin
                    $error("unexpected message: 0x%0h", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = pending_msgs.pop_front();
                    check_field("message_kind", 32'(want.message_kind),
                                32'(got.message_kind));
                    check_field("channel", 32'(want.channel), 32'(got.channel));
                    check_field("first_value", 32'(want.first_value),
                                32'(got.first_value));
                    check_field("second_value", 32'(want.second_value),
                                32'(got.second_value));
                    check_field("tdata padding", 0,
                                32'(m_axis_tdata[OUT_BYTES*8-1:OUT_BITS]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata);
        end
    end

    // Output side: random stalls, with steady stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("midi_byte_stream_parser_test: done, errors");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_realtime();
        send_byte(8'($urandom_range(ST_RT_FIRST, ST_RT_LAST)));
    endtask

    task automatic test_channel_voice();
        send_byte({NIB_NOTE_ON, 4'hF});
        send_byte(8'h00);
        send_byte({1'b0, DATA_MAX});
        // running status: a second note on without a status byte
        send_byte({1'b0, DATA_MAX});
        send_byte(8'h00);
        send_byte({NIB_PROGRAM, 4'h0});
        send_byte({1'b0, DATA_MAX});
        send_byte({NIB_CHAN_PRES, 4'h5});
        send_byte(8'h2A);
        send_byte({NIB_PITCH, 4'h3});
        send_byte(8'h00);
        send_byte({1'b0, DATA_MAX});
    endtask

    task automatic test_system_msgs();
        // controller 119 is a normal controller, 120 is channel mode
        send_byte({NIB_CTRL, 4'h2});
        send_byte(8'd119);
        send_byte(ST_RT_FIRST + 8'd2);  // real-time between data bytes
        send_byte(8'h01);
        send_byte({1'b0, CTRL_MODE_FIRST});
        send_byte({1'b0, DATA_MAX});
        send_byte(ST_MTC_QF);
        send_byte({1'b0, DATA_MAX});
        send_byte(ST_SONG_POS);
        send_byte(8'h00);
        send_byte({1'b0, DATA_MAX});
        send_byte(ST_SONG_SEL);
        send_byte(8'h05);
        send_byte(ST_TUNE_REQ);
        send_byte(ST_SYSEX);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(ST_SYSEX_END);
        send_byte(ST_UNDEF_F4);
        send_byte(ST_UNDEF_F5);
        send_byte(8'h11);  // no running status, dropped
        send_byte(ST_RT_LAST);
    endtask

    task automatic send_random_message();
        int unsigned pick;
        int unsigned n;
        logic [3:0] nib;
        logic [7:0] st;
        logic [6:0] d;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            nib = 4'($urandom_range(NIB_NOTE_OFF, NIB_PITCH));
            st = {nib, 4'($urandom)};
            if (gen_status[7] && gen_status < ST_SYSEX && $urandom_range(0, 2) == 0) begin
                st = gen_status;
            end else begin
                send_byte(st);
                gen_status = st;
            end
            if (st[7:4] == NIB_CTRL && $urandom_range(0, 1) == 0)
                d = 7'($urandom_range(110, DATA_MAX));
            else
                d = 7'($urandom_range(0, DATA_MAX));
            if ($urandom_range(0, 9) == 0)
                send_realtime();
            send_byte({1'b0, d});
            if (st[7:4] != NIB_PROGRAM && st[7:4] != NIB_CHAN_PRES) begin
                if ($urandom_range(0, 9) == 0)
                    send_realtime();
                send_byte({1'b0, 7'($urandom)});
            end
        end else if (pick < 75) begin
            case ($urandom_range(0, 3))
                0: st = ST_MTC_QF;
                1: st = ST_SONG_POS;
                2: st = ST_SONG_SEL;
                default: st = ST_TUNE_REQ;
            endcase
            send_byte(st);
            if (st != ST_TUNE_REQ)
                send_byte({1'b0, 7'($urandom)});
            if (st == ST_SONG_POS)
                send_byte({1'b0, 7'($urandom)});
            gen_status = ST_NONE;
        end else if (pick < 83) begin
            send_byte(ST_SYSEX);
            n = $urandom_range(0, 4);
            repeat (n) send_byte({1'b0, 7'($urandom)});
            send_byte(ST_SYSEX_END);
            gen_status = ST_NONE;
        end else if (pick < 93) begin
            // broken message: any status and a random count of data bytes
            send_byte(8'($urandom_range(8'h80, ST_RT_LAST)));
            n = $urandom_range(0, 2);
            repeat (n) send_byte({1'b0, 7'($urandom)});
            gen_status = ST_NONE;
        end else begin
            send_byte(8'($urandom_range(0, 255)));
            gen_status = ST_NONE;
        end
    endtask

    task automatic test_random_stream();
        int unsigned target;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 49) == 0)
                src_steady = !src_steady;
            if ($urandom_range(0, 49) == 0)
                sink_steady = !sink_steady;
            send_random_message();
        end
        src_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_channel_voice();
        test_system_msgs();
        test_random_stream();
        s_axis_tvalid <= 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge i_clk);
        // catch any extra message still in flight
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("midi_byte_stream_parser_test: done, clean");
        else
            $display("midi_byte_stream_parser_test: done, errors");
        $finish;
    end

endmodule
